// ----- rtl/bcs_pkg.sv -----
`timescale 1ns / 1ps
package bcs_pkg;

   localparam int PIX_W    = 12;
   localparam int SUM_W    = 34;
   localparam int OUT_W    = 16;
   localparam int SCALED_W = 38;
   localparam int CH_W     = 2;
   localparam int CHANNELS = 4;
   localparam int DIM_REG_W  = 13;
   localparam int BITS_REG_W = 4;
   localparam int SHIFT_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PIX_W-1:0]      PIX_ALL_ONES  = '1;
   localparam logic [DIM_REG_W-1:0]  WIDTH_RESET   = 13'd1920;
   localparam logic [DIM_REG_W-1:0]  HEIGHT_RESET  = 13'd1080;
   localparam logic [BITS_REG_W-1:0] BITS_RESET    = 4'd12;
   localparam logic [BITS_REG_W-1:0] BITS_LOW      = 4'd10;
   localparam logic [BITS_REG_W-1:0] BITS_HIGH     = 4'd12;
   localparam logic [4:0]            OUT_BITS      = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_SAMPLE_BITS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [CH_W-1:0]  channel;
      logic             frame_end;
   } entry_type;

endpackage

// ----- rtl/bcs_queue.sv -----
`timescale 1ns / 1ps
module bcs_queue #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("queue lost an item");
endmodule

// ----- rtl/bcs_front.sv -----
`timescale 1ns / 1ps
module bcs_front #(
   parameter int MAX_DIM = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [bcs_pkg::PIX_W-1:0]          pixel,
   output logic                               full,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bcs_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               q_full,
   output logic                               q_push,
   output bcs_pkg::entry_type                 q_data,
   output logic [bcs_pkg::SHIFT_W-1:0]        shift
);
   import bcs_pkg::*;

   localparam int DIM_W = ($clog2(MAX_DIM + 1) > DIM_REG_W) ? $clog2(MAX_DIM + 1) : DIM_REG_W;
   localparam int CNT_W = $clog2(MAX_DIM);
   localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM) & ~DIM_W'(1);
   localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);

   logic [DIM_REG_W-1:0]  width_ff, height_ff;
   logic [BITS_REG_W-1:0] bits_ff;
   logic [CNT_W-1:0]      col_ff, col_in;
   logic [CNT_W-1:0]      row_ff, row_in;
   logic [DIM_W-1:0]      width_eff, height_eff, col_next, row_next;
   logic [BITS_REG_W-1:0] bits_eff;
   logic [PIX_W-1:0]      top, pix_clamped;
   logic                  accept, row_wrap, frame_wrap;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] reg_value);
      logic [DIM_W-1:0] d;
      d = DIM_W'({reg_value[DIM_REG_W-1:1], 1'b0});
      if (d < DIM_MIN) begin
         d = DIM_MIN;
      end else if (d > DIM_CAP) begin
         d = DIM_CAP;
      end
      return d;
   endfunction

   assign csr_ready  = 1'b1;
   assign full       = q_full;
   assign accept     = push && !q_full;
   assign width_eff  = eff_dim(width_ff);
   assign height_eff = eff_dim(height_ff);

   always_comb begin
      if (bits_ff inside {[BITS_LOW:BITS_HIGH]}) begin
         bits_eff = bits_ff;
      end else if (bits_ff < BITS_LOW) begin
         bits_eff = BITS_LOW;
      end else begin
         bits_eff = BITS_HIGH;
      end
   end

   // top of range for the depth, then clamp
   assign top         = PIX_ALL_ONES >> (BITS_HIGH - bits_eff);
   assign pix_clamped = (pixel > top) ? top : pixel;
   assign shift       = SHIFT_W'(OUT_BITS - 5'(bits_eff));

   assign col_next   = DIM_W'(col_ff) + 1'b1;
   assign row_next   = DIM_W'(row_ff) + 1'b1;
   assign row_wrap   = (col_next >= width_eff);
   assign frame_wrap = row_wrap && (row_next >= height_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!row_wrap) begin
            col_in = col_next[CNT_W-1:0];
         end else begin
            col_in = '0;
            row_in = frame_wrap ? '0 : row_next[CNT_W-1:0];
         end
      end
   end

   assign q_push           = accept;
   assign q_data.pixel     = pix_clamped;
   assign q_data.channel   = {row_ff[0], col_ff[0]};
   assign q_data.frame_end = frame_wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         bits_ff   <= BITS_RESET;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_data[DIM_REG_W-1:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_data[DIM_REG_W-1:0];
               CSR_SAMPLE_BITS:  bits_ff   <= csr_data[BITS_REG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (q_push && q_data.frame_end) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters not cleared at frame end");
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == CSR_FRAME_WIDTH) |=>
      (width_ff == $past(csr_data[DIM_REG_W-1:0])))
      else $error("frame width write lost");
endmodule

// ----- rtl/bcs_back.sv -----
`timescale 1ns / 1ps
module bcs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  bcs_pkg::entry_type               q_data,
   output logic                             q_pop,
   input  logic [bcs_pkg::SHIFT_W-1:0]      shift,
   output logic [bcs_pkg::CH_W-1:0]         rsp_channel,
   output logic [bcs_pkg::OUT_W-1:0]        rsp_min_value,
   output logic [bcs_pkg::OUT_W-1:0]        rsp_max_value,
   output logic [bcs_pkg::SCALED_W-1:0]     rsp_scaled_sum,
   output logic                             rsp_last,
   output logic                             empty,
   input  logic                             pop
);
   import bcs_pkg::*;

   logic [PIX_W-1:0] min_ff  [CHANNELS];
   logic [PIX_W-1:0] max_ff  [CHANNELS];
   logic [SUM_W-1:0] sum_ff  [CHANNELS];
   logic [PIX_W-1:0] bank_min_ff [CHANNELS];
   logic [PIX_W-1:0] bank_max_ff [CHANNELS];
   logic [SUM_W-1:0] bank_sum_ff [CHANNELS];
   logic [CH_W-1:0]  bank_idx_ff;
   logic             bank_valid_ff;

   logic [PIX_W-1:0] upd_min, upd_max;
   logic [SUM_W-1:0] upd_sum;
   logic             bank_load, bank_pop;

   // a frame-end item waits until the previous frame's last result is leaving
   assign q_pop     = !q_empty &&
                      (!q_data.frame_end || !bank_valid_ff || (bank_pop && rsp_last));
   assign bank_load = q_pop && q_data.frame_end;
   assign bank_pop  = pop && bank_valid_ff;

   assign upd_min = (q_data.pixel < min_ff[q_data.channel]) ? q_data.pixel
                                                            : min_ff[q_data.channel];
   assign upd_max = (q_data.pixel > max_ff[q_data.channel]) ? q_data.pixel
                                                            : max_ff[q_data.channel];
   assign upd_sum = sum_ff[q_data.channel] + SUM_W'(q_data.pixel);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            min_ff[c] <= PIX_ALL_ONES;
            max_ff[c] <= '0;
            sum_ff[c] <= '0;
         end
      end else if (bank_load) begin
         for (int c = 0; c < CHANNELS; c++) begin
            min_ff[c] <= PIX_ALL_ONES;
            max_ff[c] <= '0;
            sum_ff[c] <= '0;
         end
      end else if (q_pop) begin
         min_ff[q_data.channel] <= upd_min;
         max_ff[q_data.channel] <= upd_max;
         sum_ff[q_data.channel] <= upd_sum;
      end
   end

   // snapshot with the final item folded in
   always_ff @(posedge clock) begin
      if (bank_load) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (CH_W'(c) == q_data.channel) begin
               bank_min_ff[c] <= upd_min;
               bank_max_ff[c] <= upd_max;
               bank_sum_ff[c] <= upd_sum;
            end else begin
               bank_min_ff[c] <= min_ff[c];
               bank_max_ff[c] <= max_ff[c];
               bank_sum_ff[c] <= sum_ff[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_valid_ff <= 1'b0;
         bank_idx_ff   <= '0;
      end else if (bank_load) begin
         bank_valid_ff <= 1'b1;
         bank_idx_ff   <= '0;
      end else if (bank_pop) begin
         bank_idx_ff <= bank_idx_ff + 1'b1;
         if (bank_idx_ff == CH_W'(CHANNELS - 1)) begin
            bank_valid_ff <= 1'b0;
         end
      end
   end

   assign empty          = !bank_valid_ff;
   assign rsp_channel    = bank_idx_ff;
   assign rsp_last       = (bank_idx_ff == CH_W'(CHANNELS - 1));
   assign rsp_min_value  = OUT_W'(bank_min_ff[bank_idx_ff]) << shift;
   assign rsp_max_value  = OUT_W'(bank_max_ff[bank_idx_ff]) << shift;
   assign rsp_scaled_sum = SCALED_W'(bank_sum_ff[bank_idx_ff]) << shift;

   assert property (@(posedge clock) disable iff (reset)
      bank_load |=> (bank_valid_ff && bank_idx_ff == '0))
      else $error("result bank not opened at channel zero");
   assert property (@(posedge clock) disable iff (reset)
      (bank_pop && rsp_last && !bank_load) |=> !bank_valid_ff)
      else $error("result bank still open after last item");
endmodule

// ----- rtl/bayer_channel_statistics.sv -----
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     push / full            req_pixel
// result    empty / pop            rsp_channel, rsp_min_value, rsp_max_value,
//                                  rsp_scaled_sum, rsp_last
// config    csr_valid / csr_ready  csr_index, csr_data
//
// One pixel is taken every cycle unless full; the front classifies it and the
// back folds it into per-channel statistics as it leaves the two-entry queue.
// At frame end four results follow, one per cycle with pop high, from a snapshot
// bank. Reset is synchronous and restores registers, counters and statistics.
// Only a frame-end pixel can stall the back, while the previous frame's four
// results are still unread; pixels keep flowing into the queue until it fills.
module bayer_channel_statistics #(
   parameter int MAX_DIM = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [bcs_pkg::PIX_W-1:0]          req_pixel,
   output logic                               full,
   output logic [bcs_pkg::CH_W-1:0]           rsp_channel,
   output logic [bcs_pkg::OUT_W-1:0]          rsp_min_value,
   output logic [bcs_pkg::OUT_W-1:0]          rsp_max_value,
   output logic [bcs_pkg::SCALED_W-1:0]       rsp_scaled_sum,
   output logic                               rsp_last,
   output logic                               empty,
   input  logic                               pop,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bcs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bcs_pkg::*;

   localparam int ENTRY_W = $bits(entry_type);

   entry_type             push_entry, pop_entry;
   logic [ENTRY_W-1:0]    pop_bits;
   logic                  q_push, q_pop, q_full, q_empty;
   logic [SHIFT_W-1:0]    shift;

   bcs_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pixel     (req_pixel),
      .full      (full),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (push_entry),
      .shift     (shift)
   );

   bcs_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_bits),
      .empty     (q_empty)
   );

   assign pop_entry = entry_type'(pop_bits);

   bcs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (pop_entry),
      .q_pop          (q_pop),
      .shift          (shift),
      .rsp_channel    (rsp_channel),
      .rsp_min_value  (rsp_min_value),
      .rsp_max_value  (rsp_max_value),
      .rsp_scaled_sum (rsp_scaled_sum),
      .rsp_last       (rsp_last),
      .empty          (empty),
      .pop            (pop)
   );
endmodule

// ----- tb/sv/bayer_channel_statistics_test.sv -----
`timescale 1ns / 1ps
module bayer_channel_statistics_test;
   import bcs_pkg::*;

   localparam int MAX_DIM        = 4096;
   localparam int RANDOM_PIXELS  = 420;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [OUT_W-1:0]    min_value;
      logic [OUT_W-1:0]    max_value;
      logic [SCALED_W-1:0] scaled_sum;
      logic                is_last;
   } channel_stats_type;

   // one 2x2 frame per row; pixel k lands on channel k
   typedef struct packed {
      logic [BITS_REG_W-1:0]    depth_reg;
      logic [0:3][PIX_W-1:0]    pixels;
      logic                     typed;
      logic [0:3][OUT_W-1:0]    values;
   } frame_row_type;

   localparam frame_row_type DIRECTED_FRAMES [6] = '{
      '{4'd12, {4{12'h000}}, 1'b1, {4{16'h0000}}},
      '{4'd12, {4{12'hFFF}}, 1'b1, {4{16'hFFF0}}},
      '{4'd10, {12'hFFF, 12'h3FF, 12'h400, 12'h000}, 1'b1,
               {16'hFFC0, 16'hFFC0, 16'hFFC0, 16'h0000}},
      '{4'd11, {12'h7FF, 12'h800, 12'h001, 12'hFFF}, 1'b1,
               {16'hFFE0, 16'hFFE0, 16'h0020, 16'hFFE0}},
      '{4'd0,  {12'h001, 12'h002, 12'h003, 12'h3FF}, 1'b1,
               {16'h0040, 16'h0080, 16'h00C0, 16'hFFC0}},
      '{4'd15, {12'h555, 12'hAAA, 12'h800, 12'h7FF}, 1'b0, {4{16'h0000}}}
   };

   typedef enum logic [1:0] {
      DRAIN_EAGER,
      DRAIN_COIN,
      DRAIN_SLOW,
      DRAIN_PERIODIC
   } drain_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic [PIX_W-1:0]      req_pixel = '0;
   logic                  full;
   logic [CH_W-1:0]       rsp_channel;
   logic [OUT_W-1:0]      rsp_min_value;
   logic [OUT_W-1:0]      rsp_max_value;
   logic [SCALED_W-1:0]   rsp_scaled_sum;
   logic                  rsp_last;
   logic                  empty;
   logic                  pop = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the registers and statistics
   logic [DIM_REG_W-1:0]  cfg_width  = WIDTH_RESET;
   logic [DIM_REG_W-1:0]  cfg_height = HEIGHT_RESET;
   logic [BITS_REG_W-1:0] cfg_bits   = BITS_RESET;
   logic [DIM_REG_W-1:0]  column_pos;
   logic [DIM_REG_W-1:0]  row_pos;
   logic [PIX_W-1:0]      channel_min [CHANNELS];
   logic [PIX_W-1:0]      channel_max [CHANNELS];
   logic [SUM_W-1:0]      channel_sum [CHANNELS];

   channel_stats_type     channel_stats_due [$];
   logic                  typed_active = 1'b0;
   logic [0:3][OUT_W-1:0] typed_values;

   int             cycle_count = 0;
   int             mismatch_count = 0;
   int             results_checked = 0;
   int             pixels_sent = 0;
   int             register_writes = 0;
   int             burst_left = 0;
   int             stall_left = 0;
   drain_mode_type drain_mode = DRAIN_EAGER;

   bayer_channel_statistics #(
      .MAX_DIM(MAX_DIM)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_pixel(req_pixel),
      .full(full),
      .rsp_channel(rsp_channel),
      .rsp_min_value(rsp_min_value),
      .rsp_max_value(rsp_max_value),
      .rsp_scaled_sum(rsp_scaled_sum),
      .rsp_last(rsp_last),
      .empty(empty),
      .pop(pop),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [DIM_REG_W-1:0] frame_dim(input logic [DIM_REG_W-1:0] reg_value);
      logic [DIM_REG_W-1:0] d;
      d = reg_value & ~13'd1;
      if (d < 13'd2) d = 13'd2;
      if (d > 13'(MAX_DIM)) d = 13'(MAX_DIM);
      return d;
   endfunction

   function automatic logic [BITS_REG_W-1:0] sample_depth();
      if (cfg_bits < BITS_LOW) return BITS_LOW;
      if (cfg_bits > BITS_HIGH) return BITS_HIGH;
      return cfg_bits;
   endfunction

   task automatic clear_channel_stats();
      column_pos = '0;
      row_pos = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         channel_min[c] = PIX_ALL_ONES;
         channel_max[c] = '0;
         channel_sum[c] = '0;
      end
   endtask

   // fold one accepted pixel into the statistics; queue four results at frame end
   task automatic fold_pixel(input logic [PIX_W-1:0] pix);
      logic [BITS_REG_W-1:0] depth;
      logic [4:0]            shift;
      logic [PIX_W-1:0]      top;
      logic [PIX_W-1:0]      p;
      logic [CH_W-1:0]       ch;
      channel_stats_type     r;
      depth = sample_depth();
      shift = OUT_BITS - 5'(depth);
      top = PIX_ALL_ONES >> (BITS_HIGH - depth);
      p = (pix > top) ? top : pix;
      ch = {row_pos[0], column_pos[0]};
      if (p < channel_min[ch]) channel_min[ch] = p;
      if (p > channel_max[ch]) channel_max[ch] = p;
      channel_sum[ch] = channel_sum[ch] + SUM_W'(p);
      column_pos = column_pos + 13'd1;
      if (column_pos >= frame_dim(cfg_width)) begin
         column_pos = '0;
         row_pos = row_pos + 13'd1;
         if (row_pos >= frame_dim(cfg_height)) begin
            for (int c = 0; c < CHANNELS; c++) begin
               r.channel    = CH_W'(c);
               r.min_value  = OUT_W'(channel_min[c]) << shift;
               r.max_value  = OUT_W'(channel_max[c]) << shift;
               r.scaled_sum = SCALED_W'(channel_sum[c]) << shift;
               r.is_last    = (c == CHANNELS - 1);
               if (typed_active) begin
                  r.min_value  = typed_values[c];
                  r.max_value  = typed_values[c];
                  r.scaled_sum = SCALED_W'(typed_values[c]);
               end
               channel_stats_due = {channel_stats_due, r};
            end
            clear_channel_stats();
         end
      end
   endtask

   // leave push high when the burst goes on, so the next item follows directly
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      req_pixel <= pix;
      push <= 1'b1;
      do @(posedge clock); while (full);
      fold_pixel(pix);
      pixels_sent++;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
         burst_left--;
      end
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      push <= 1'b0;
      while (channel_stats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // hold csr_valid afterwards; the caller drops it once the batch is done
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FRAME_WIDTH:  cfg_width = value;
         CSR_FRAME_HEIGHT: cfg_height = value;
         CSR_SAMPLE_BITS:  cfg_bits = value[BITS_REG_W-1:0];
         default: ;
      endcase
      register_writes++;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] width_reg,
                            input logic [CSR_DATA_W-1:0] height_reg,
                            input logic [CSR_DATA_W-1:0] depth_reg);
      settle();
      if ($urandom_range(0, 3) == 0) write_register(CSR_SPARE, CSR_DATA_W'($urandom));
      write_register(CSR_FRAME_WIDTH, width_reg);
      write_register(CSR_FRAME_HEIGHT, height_reg);
      write_register(CSR_SAMPLE_BITS, depth_reg);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_dim();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: return CSR_DATA_W'(2 * $urandom_range(1, 4));
         7:                   return CSR_DATA_W'(2 * $urandom_range(0, 7) + 1);
         8:                   return CSR_DATA_W'($urandom_range(0, 1));
         default:             return CSR_DATA_W'($urandom_range(2, 24));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_depth();
      if ($urandom_range(0, 3) != 0)
         return {9'($urandom), 4'($urandom_range(10, 12))};
      return CSR_DATA_W'($urandom);
   endfunction

   // bias towards the clamp edge of the current depth and the field extremes
   function automatic logic [PIX_W-1:0] random_pixel();
      int top;
      top = (1 << sample_depth()) - 1;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return PIX_ALL_ONES;
         2:       return PIX_W'($urandom_range(0, 15));
         3, 4:    return PIX_W'($urandom_range(top - 3, (top + 3 > 4095) ? 4095 : top + 3));
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic send_frame();
      int pixel_total;
      pixel_total = int'(frame_dim(cfg_width)) * int'(frame_dim(cfg_height));
      repeat (pixel_total) send_pixel(random_pixel());
   endtask

   task automatic check_field(input string field, input logic [SCALED_W-1:0] want,
                              input logic [SCALED_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : drain_side
      channel_stats_type due;
      if (!reset && pop && !empty) begin
         if (channel_stats_due.size() == 0) begin
            $display("%0t ns: unexpected result on channel %0d, none outstanding",
                     $time, rsp_channel);
            mismatch_count++;
         end else begin
            due = channel_stats_due.pop_front();
            check_field("channel", SCALED_W'(due.channel), SCALED_W'(rsp_channel));
            check_field("min_value", SCALED_W'(due.min_value), SCALED_W'(rsp_min_value));
            check_field("max_value", SCALED_W'(due.max_value), SCALED_W'(rsp_max_value));
            check_field("scaled_sum", due.scaled_sum, rsp_scaled_sum);
            check_field("last", SCALED_W'(due.is_last), SCALED_W'(rsp_last));
            results_checked++;
         end
      end
      if (stall_left == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (drain_mode)
         DRAIN_EAGER:    pop <= 1'b1;
         DRAIN_COIN:     pop <= 1'($urandom_range(0, 1));
         DRAIN_SLOW:     pop <= ($urandom_range(0, 7) == 0);
         DRAIN_PERIODIC: pop <= (stall_left[2:0] == 3'd0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int directed_pixels;
      clear_channel_stats();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 2x2 frames; the first runs at the reset depth
      write_register(CSR_FRAME_WIDTH, 13'd2);
      write_register(CSR_FRAME_HEIGHT, 13'd2);
      csr_valid <= 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (DIRECTED_FRAMES[i].depth_reg != cfg_bits) begin
            settle();
            write_register(CSR_SAMPLE_BITS, CSR_DATA_W'(DIRECTED_FRAMES[i].depth_reg));
            csr_valid <= 1'b0;
         end
         typed_active = DIRECTED_FRAMES[i].typed;
         typed_values = DIRECTED_FRAMES[i].values;
         for (int k = 0; k < 4; k++) send_pixel(DIRECTED_FRAMES[i].pixels[k]);
      end
      typed_active = 1'b0;
      directed_pixels = pixels_sent;

      while (pixels_sent - directed_pixels < RANDOM_PIXELS) begin
         configure(random_dim(), random_dim(), random_depth());
         repeat ($urandom_range(1, 3)) send_frame();
      end

      settle();
      $display("%0d pixels sent, %0d channel results checked (%0d frames)",
               pixels_sent, results_checked, results_checked / CHANNELS);
      $display("%0d register writes across depths 10..12 and frames 2x2 up to 24 a side",
               register_writes);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/bcs_pkg.sv
rtl/bcs_queue.sv
rtl/bcs_front.sv
rtl/bcs_back.sv
rtl/bayer_channel_statistics.sv
tb/sv/bayer_channel_statistics_test.sv
